// ===== src/aet_pkg.sv =====
// ----------------------------------------------------------------------------
// aet_pkg: shared types and constants for the expression tokenizer
// Token and error codes, lexer modes, character codes and the result record.
// ----------------------------------------------------------------------------
package aet_pkg;

    localparam int POS_BITS = 16;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    typedef enum logic [2:0] {
        TK_INTEGER  = 3'd0,
        TK_PLUS     = 3'd1,
        TK_MINUS    = 3'd2,
        TK_MULTIPLY = 3'd3,
        TK_DIVIDE   = 3'd4,
        TK_END      = 3'd5,
        TK_ERROR    = 3'd6
    } tok_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_BIG     = 2'd1,
        ERR_BADCHAR = 2'd2
    } err_code_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NUMBER = 2'd1,
        MODE_UTF8   = 2'd2
    } lex_mode_t;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_VAL   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_VAL  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_VAL  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_VAL  = 8'hF0;

    typedef struct packed {
        tok_kind_t   kind;
        logic [15:0] from;
        logic [15:0] to;
        logic [63:0] value;
        err_code_t   err;
        logic        last;
    } result_t;

    function automatic result_t make_result(
        input tok_kind_t          kind,
        input logic [POS_BITS-1:0] from,
        input logic [POS_BITS-1:0] to,
        input logic [63:0]        value,
        input err_code_t          err
    );
        result_t r;
        r.kind  = kind;
        r.from  = 16'(from);
        r.to    = 16'(to);
        r.value = value;
        r.err   = err;
        r.last  = 1'b0;
        return r;
    endfunction

endpackage

// ===== src/arith_expression_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// arith_expression_tokenizer_core: byte-stream lexer for integer arithmetic
// A request is registered in the input stage, its results in the result pair.
// Throughput: one request per cycle while token_ready is high; a request giving
//   two results stalls the next one. Set by the single result-pair register.
// Reset: asynchronous, clears lexer state and the valid flags of both stages.
// ----------------------------------------------------------------------------
module arith_expression_tokenizer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        kind,
    input  logic [7:0]  text_byte,
    output logic        token_valid,
    input  logic        token_ready,
    output logic [2:0]  token_class,
    output logic [15:0] range_from,
    output logic [15:0] range_to,
    output logic [63:0] token_value,
    output logic [1:0]  error_code,
    output logic        last_of_run
);
    import aet_pkg::*;

    // input stage
    logic                in_valid_reg;
    logic                in_kind_reg;
    logic [7:0]          in_byte_reg;

    // lexer state
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    lex_mode_t           mode_reg, mode_next;
    logic [63:0]         acc_reg, acc_next;
    logic                ovf_reg, ovf_next;
    logic [1:0]          utf_left_reg, utf_left_next;
    logic                halt_reg, halt_next;

    // result pair
    result_t             slot0_reg, slot1_reg;
    logic [1:0]          cnt_reg;

    logic                out_free;
    logic                advance;
    logic                out_fire;

    result_t             r0, r1;
    logic [1:0]          n_res;

    // between-token classification of the current byte
    logic                bt_emit;
    result_t             bt_res;
    lex_mode_t           bt_mode;
    logic [POS_BITS-1:0] bt_start;
    logic [63:0]         bt_acc;
    logic [1:0]          bt_utf;
    logic                bt_halt;

    logic                is_digit;
    logic [3:0]          digit;
    logic [67:0]         acc_x10;
    logic [POS_BITS-1:0] pos_inc;

    assign out_fire   = token_valid && token_ready;
    assign out_free   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && token_ready);
    assign advance    = in_valid_reg && out_free;
    assign item_ready = !in_valid_reg || out_free;

    assign is_digit = (in_byte_reg >= CH_ZERO) && (in_byte_reg <= CH_NINE);
    assign digit    = in_byte_reg[3:0];
    // acc * 10 + d; anything above bit 63 is an overflow
    assign acc_x10  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {64'd0, digit};
    assign pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    always_comb
    begin
        bt_emit  = 1'b0;
        bt_res   = make_result(TK_ERROR, pos_reg, pos_inc, 64'd0, ERR_BADCHAR);
        bt_mode  = MODE_IDLE;
        bt_start = start_reg;
        bt_acc   = '0;
        bt_utf   = utf_left_reg;
        bt_halt  = 1'b0;
        case (in_byte_reg)
            CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF:
            begin
            end
            CH_PLUS:
            begin
                bt_emit = 1'b1;
                bt_res  = make_result(TK_PLUS, pos_reg, pos_inc, {56'd0, in_byte_reg}, ERR_NONE);
            end
            CH_MINUS:
            begin
                bt_emit = 1'b1;
                bt_res  = make_result(TK_MINUS, pos_reg, pos_inc, {56'd0, in_byte_reg}, ERR_NONE);
            end
            CH_STAR:
            begin
                bt_emit = 1'b1;
                bt_res  = make_result(TK_MULTIPLY, pos_reg, pos_inc, {56'd0, in_byte_reg},
                                      ERR_NONE);
            end
            CH_SLASH:
            begin
                bt_emit = 1'b1;
                bt_res  = make_result(TK_DIVIDE, pos_reg, pos_inc, {56'd0, in_byte_reg},
                                      ERR_NONE);
            end
            default:
            begin
                if (is_digit)
                begin
                    bt_mode  = MODE_NUMBER;
                    bt_start = pos_reg;
                    bt_acc   = {60'd0, digit};
                end
                else
                begin
                    if ((in_byte_reg & LEAD2_MASK) == LEAD2_VAL)
                        bt_utf = 2'd1;
                    else if ((in_byte_reg & LEAD3_MASK) == LEAD3_VAL)
                        bt_utf = 2'd2;
                    else if ((in_byte_reg & LEAD4_MASK) == LEAD4_VAL)
                        bt_utf = 2'd3;
                    else
                        bt_utf = 2'd0;
                    if (bt_utf == 2'd0)
                    begin
                        bt_emit = 1'b1;
                        bt_halt = 1'b1;
                    end
                    else
                    begin
                        bt_mode  = MODE_UTF8;
                        bt_start = pos_reg;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        pos_next      = pos_reg;
        start_next    = start_reg;
        mode_next     = mode_reg;
        acc_next      = acc_reg;
        ovf_next      = ovf_reg;
        utf_left_next = utf_left_reg;
        halt_next     = halt_reg;
        r0            = make_result(TK_END, pos_reg, pos_reg, 64'd0, ERR_NONE);
        r1            = r0;
        n_res         = 2'd0;

        if (advance)
        begin
            if (in_kind_reg == KIND_END)
            begin
                if (!halt_reg)
                begin
                    if (mode_reg == MODE_NUMBER)
                    begin
                        r0 = ovf_reg
                           ? make_result(TK_ERROR, start_reg, pos_reg, 64'd0, ERR_BIG)
                           : make_result(TK_INTEGER, start_reg, pos_reg, acc_reg, ERR_NONE);
                        n_res = 2'd1;
                    end
                    else if (mode_reg == MODE_UTF8)
                    begin
                        r0    = make_result(TK_ERROR, start_reg, pos_reg, 64'd0, ERR_BADCHAR);
                        n_res = 2'd1;
                    end
                end
                if (n_res == 2'd1)
                    r1 = make_result(TK_END, pos_reg, pos_reg, 64'd0, ERR_NONE);
                n_res         = n_res + 2'd1;
                pos_next      = '0;
                start_next    = '0;
                mode_next     = MODE_IDLE;
                acc_next      = '0;
                ovf_next      = 1'b0;
                utf_left_next = 2'd0;
                halt_next     = 1'b0;
            end
            else
            begin
                if (!halt_reg)
                begin
                    case (mode_reg)
                        MODE_NUMBER:
                        begin
                            if (is_digit)
                            begin
                                if (acc_x10[67:64] != 4'd0)
                                    ovf_next = 1'b1;
                                else
                                    acc_next = acc_x10[63:0];
                            end
                            else if (ovf_reg)
                            begin
                                r0        = make_result(TK_ERROR, start_reg, pos_reg, 64'd0,
                                                        ERR_BIG);
                                n_res     = 2'd1;
                                halt_next = 1'b1;
                                mode_next = MODE_IDLE;
                                acc_next  = '0;
                                ovf_next  = 1'b0;
                            end
                            else
                            begin
                                // integer closes, then the byte is lexed on its own
                                r0            = make_result(TK_INTEGER, start_reg, pos_reg,
                                                            acc_reg, ERR_NONE);
                                r1            = bt_res;
                                n_res         = bt_emit ? 2'd2 : 2'd1;
                                mode_next     = bt_mode;
                                start_next    = bt_start;
                                acc_next      = bt_acc;
                                ovf_next      = 1'b0;
                                utf_left_next = bt_utf;
                                halt_next     = bt_halt;
                            end
                        end
                        MODE_UTF8:
                        begin
                            halt_next = 1'b1;
                            if ((in_byte_reg & CONT_MASK) == CONT_VAL)
                            begin
                                utf_left_next = utf_left_reg - 2'd1;
                                if (utf_left_reg == 2'd1)
                                begin
                                    r0        = make_result(TK_ERROR, start_reg, pos_inc,
                                                            64'd0, ERR_BADCHAR);
                                    n_res     = 2'd1;
                                    mode_next = MODE_IDLE;
                                end
                                else
                                    halt_next = 1'b0;
                            end
                            else
                            begin
                                // short sequence: this byte is dropped
                                r0            = make_result(TK_ERROR, start_reg, pos_reg,
                                                            64'd0, ERR_BADCHAR);
                                n_res         = 2'd1;
                                mode_next     = MODE_IDLE;
                                utf_left_next = 2'd0;
                            end
                        end
                        default:
                        begin
                            r0            = bt_res;
                            n_res         = bt_emit ? 2'd1 : 2'd0;
                            mode_next     = bt_mode;
                            start_next    = bt_start;
                            acc_next      = bt_acc;
                            ovf_next      = 1'b0;
                            utf_left_next = bt_utf;
                            halt_next     = bt_halt;
                        end
                    endcase
                end
                pos_next = pos_inc;
            end
        end

        r0.last = (n_res == 2'd1);
        r1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
            pos_reg      <= '0;
            start_reg    <= '0;
            mode_reg     <= MODE_IDLE;
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
            utf_left_reg <= 2'd0;
            halt_reg     <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                cnt_reg <= n_res;
            else if (out_fire)
                cnt_reg <= cnt_reg - 2'd1;

            pos_reg      <= pos_next;
            start_reg    <= start_next;
            mode_reg     <= mode_next;
            acc_reg      <= acc_next;
            ovf_reg      <= ovf_next;
            utf_left_reg <= utf_left_next;
            halt_reg     <= halt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_kind_reg <= kind;
            in_byte_reg <= text_byte;
        end

        if (advance)
        begin
            slot0_reg <= r0;
            slot1_reg <= r1;
        end
        else if (out_fire)
            slot0_reg <= slot1_reg;
    end

    assign token_valid = (cnt_reg != 2'd0);
    assign token_class = slot0_reg.kind;
    assign range_from  = slot0_reg.from;
    assign range_to    = slot0_reg.to;
    assign token_value = slot0_reg.value;
    assign error_code  = slot0_reg.err;
    assign last_of_run = slot0_reg.last;

endmodule
